### sv/lfsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared widths, codes, control structs and a helper for the slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 10;
    localparam int HANDLE_W = 32;
    localparam int STATUS_W = 2;

    // default pool size
    localparam int LFSA_SLOTS = 1024;

    // bitmap word geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ID = 2'd2;

    // controller to datapath actions
    typedef struct packed {
        logic load;      // latch an input transfer
        logic clr;       // clear one bitmap word
        logic exec;      // decode item and issue first read
        logic scan;      // check one bitmap word for a free slot
        logic acc;       // finish register, free or lookup
        logic out_load;  // move result to output register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_alloc;
        logic exec_done;
        logic scan_done;
        logic clr_last;
        logic out_free;
    } dp_stat_t;

    // index of lowest zero bit in a bitmap word
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/lowest_free_slot_allocator.sv
`default_nettype none
// From input transfer to result valid: decode, then a bitmap scan for
// allocate or a finishing step for register, free and lookup, skipped for
// full or bad id; allocate scans k 32-bit bitmap words upward from the hint
// (0 .. ceil(SLOTS/32), zero when the hint sits on the last slot).
// One item in flight: input reopens in the cycle after the result is loaded.
// Reset: async, active low; then a clearing pass over all ceil(SLOTS/32)
// words zeroes the used bitmap, with in_stall high throughout.
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Slot-ID pool with used bitmap, handle store and a lowest-free hint.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator #(
    parameter int SLOTS = lfsa_pkg::LFSA_SLOTS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lfsa_pkg::CMD_W-1:0]    cmd,
    input  wire logic [lfsa_pkg::ID_W-1:0]     slot_id,
    input  wire logic [lfsa_pkg::HANDLE_W-1:0] handle,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lfsa_pkg::ID_W-1:0]          id_out,
    output logic [lfsa_pkg::HANDLE_W-1:0]      handle_out,
    output logic                               found,
    output logic [lfsa_pkg::STATUS_W-1:0]      status
);
    import lfsa_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t stat;

    // sequencer
    lfsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .dcmd     (dcmd)
    );

    // storage and result path
    lfsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dcmd       (dcmd),
        .stat       (stat),
        .cmd        (cmd),
        .slot_id    (slot_id),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .id_out     (id_out),
        .handle_out (handle_out),
        .found      (found),
        .status     (status)
    );

    // one item at a time: the cycle after a transfer the input is closed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in flight");

    // a hit only comes from a successful lookup
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == STAT_OK))
        else $error("found set with non-ok status");

    // no handle leaks out without a hit
    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (handle_out == '0))
        else $error("handle_out nonzero without found");

    // full result carries id zero
    a_full_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_FULL)) |-> (id_out == '0))
        else $error("full result with nonzero id");

endmodule
`default_nettype wire

### sv/lfsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_ctrl
// Sequencer for the slot allocator: clearing pass, decode, bitmap scan,
// read-modify-write and result hand-off.
// ----------------------------------------------------------------------------
module lfsa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire lfsa_pkg::dp_stat_t stat,
    output lfsa_pkg::dp_cmd_t       dcmd
);
    import lfsa_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // input side is open only between items
    assign in_stall = (state_reg != ST_IDLE);

    // next state and datapath actions
    always_comb
    begin
        state_next = state_reg;
        dcmd       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                dcmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dcmd.load  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                dcmd.exec = 1'b1;
                if (stat.exec_done)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.is_alloc)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_SCAN:
            begin
                dcmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ACC:
            begin
                dcmd.acc   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    dcmd.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### sv/lfsa_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_dp
// Datapath of the slot allocator: used bitmap and handle memories, hint,
// scan counter, result and output registers.
// ----------------------------------------------------------------------------
module lfsa_dp #(
    parameter int SLOTS = lfsa_pkg::LFSA_SLOTS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lfsa_pkg::dp_cmd_t             dcmd,
    output lfsa_pkg::dp_stat_t                 stat,
    input  wire logic [lfsa_pkg::CMD_W-1:0]    cmd,
    input  wire logic [lfsa_pkg::ID_W-1:0]     slot_id,
    input  wire logic [lfsa_pkg::HANDLE_W-1:0] handle,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lfsa_pkg::ID_W-1:0]          id_out,
    output logic [lfsa_pkg::HANDLE_W-1:0]      handle_out,
    output logic                               found,
    output logic [lfsa_pkg::STATUS_W-1:0]      status
);
    import lfsa_pkg::*;

    localparam int IW    = $clog2(SLOTS);
    localparam int HW    = $clog2(SLOTS + 1);
    localparam int EW    = (HW > ID_W) ? HW : ID_W;
    localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(WORDS * WORD_W + 1);
    localparam int CW    = PW - BIT_W;

    // memories
    logic [WORD_W-1:0]   bm_mem [WORDS];
    logic [HANDLE_W-1:0] h_mem  [SLOTS];

    // control registers
    logic [HW-1:0]    hint_reg;
    logic [CW-1:0]    cnt_reg;
    logic             first_reg;
    logic             out_valid_reg;

    // payload registers
    logic [CMD_W-1:0]    cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [BIT_W-1:0]    start_reg;
    logic [WORD_W-1:0]   bm_rdata_reg;
    logic [HANDLE_W-1:0] h_rdata_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic                res_found_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [ID_W-1:0]     id_out_reg;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic                found_reg;
    logic [STATUS_W-1:0] status_reg;

    // decode of the latched item
    logic [EW-1:0]     id_ext;
    logic              bad_id;
    logic [IW-1:0]     idx;
    logic [PW-1:0]     idx_pos;
    logic [CW-1:0]     id_word;
    logic [BIT_W-1:0]  id_bit;
    logic [WORD_W-1:0] id_onehot;
    logic              is_alloc;
    logic              is_lookup;
    logic              full;
    logic [PW-1:0]     pos0;
    logic [CW-1:0]     word0;
    logic              word0_beyond;
    logic              exec_done;
    logic [EW-1:0]     hint_ext;

    assign id_ext       = EW'(id_reg);
    assign bad_id       = (id_ext >= EW'(SLOTS));
    assign idx          = id_ext[IW-1:0];
    assign idx_pos      = PW'(idx);
    assign id_word      = idx_pos[PW-1:BIT_W];
    assign id_bit       = idx_pos[BIT_W-1:0];
    assign id_onehot    = WORD_W'(1) << id_bit;
    assign is_alloc     = (cmd_reg == CMD_ALLOC);
    assign is_lookup    = (cmd_reg == CMD_LOOKUP);
    assign full         = (hint_reg >= HW'(SLOTS));
    assign pos0         = PW'(hint_reg) + PW'(1);
    assign word0        = pos0[PW-1:BIT_W];
    assign word0_beyond = (word0 >= CW'(WORDS));
    assign exec_done    = is_alloc ? (full || word0_beyond) : bad_id;
    assign hint_ext     = EW'(hint_reg);

    // scan of one bitmap word
    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] masked;
    logic              hit;
    logic [PW-1:0]     hit_pos;
    logic              hit_in_range;
    logic [CW:0]       cnt_inc;
    logic              scan_last;
    logic              scan_done;

    assign low_mask     = first_reg ? ((WORD_W'(1) << start_reg) - WORD_W'(1)) : '0;
    assign masked       = bm_rdata_reg | low_mask;
    assign hit          = (~masked != '0);
    assign hit_pos      = {cnt_reg, lowest_zero(masked)};
    assign hit_in_range = (hit_pos < PW'(SLOTS));
    assign cnt_inc      = (CW + 1)'(cnt_reg) + (CW + 1)'(1);
    assign scan_last    = (cnt_inc >= (CW + 1)'(WORDS));
    assign scan_done    = hit || scan_last;

    // status to controller
    assign stat.is_alloc  = is_alloc;
    assign stat.exec_done = exec_done;
    assign stat.scan_done = scan_done;
    assign stat.clr_last  = (cnt_reg == CW'(WORDS - 1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // bitmap port control
    logic              bm_re;
    logic [AW-1:0]     bm_raddr;
    logic              bm_we;
    logic [AW-1:0]     bm_waddr;
    logic [WORD_W-1:0] bm_wdata;

    always_comb
    begin
        bm_re    = (dcmd.exec && !exec_done) || (dcmd.scan && !scan_done);
        bm_raddr = dcmd.scan ? cnt_inc[AW-1:0]
                 : (is_alloc ? word0[AW-1:0] : id_word[AW-1:0]);
        bm_we    = dcmd.clr || (dcmd.acc && !is_lookup);
        bm_waddr = dcmd.clr ? cnt_reg[AW-1:0] : id_word[AW-1:0];
        if (dcmd.clr)
        begin
            bm_wdata = '0;
        end
        else if (cmd_reg == CMD_REGISTER)
        begin
            bm_wdata = bm_rdata_reg | id_onehot;
        end
        else
        begin
            bm_wdata = bm_rdata_reg & ~id_onehot;
        end
    end

    // used bitmap memory
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rdata_reg <= bm_mem[bm_raddr];
        end
    end

    // handle memory
    always_ff @(posedge clk)
    begin
        if (dcmd.acc && (cmd_reg == CMD_REGISTER))
        begin
            h_mem[idx] <= handle_reg;
        end
        if (dcmd.exec && !is_alloc)
        begin
            h_rdata_reg <= h_mem[idx];
        end
    end

    // hint, scan counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg      <= '0;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dcmd.clr)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (dcmd.exec && is_alloc && !full)
            begin
                cnt_reg   <= word0;
                first_reg <= 1'b1;
                if (word0_beyond)
                begin
                    hint_reg <= HW'(SLOTS);
                end
            end
            if (dcmd.scan)
            begin
                first_reg <= 1'b0;
                if (hit)
                begin
                    hint_reg <= hit_in_range ? hit_pos[HW-1:0] : HW'(SLOTS);
                end
                else if (scan_last)
                begin
                    hint_reg <= HW'(SLOTS);
                end
                else
                begin
                    cnt_reg <= cnt_inc[CW-1:0];
                end
            end
            if (dcmd.acc)
            begin
                if ((cmd_reg == CMD_REGISTER) && (HW'(idx) == hint_reg))
                begin
                    hint_reg <= hint_reg + HW'(1);
                end
                else if ((cmd_reg == CMD_FREE) && (HW'(idx) < hint_reg))
                begin
                    hint_reg <= HW'(idx);
                end
            end
            if (dcmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, result and output payload
    always_ff @(posedge clk)
    begin
        if (dcmd.load)
        begin
            cmd_reg    <= cmd;
            id_reg     <= slot_id;
            handle_reg <= handle;
        end
        if (dcmd.exec)
        begin
            start_reg      <= pos0[BIT_W-1:0];
            res_handle_reg <= '0;
            res_found_reg  <= 1'b0;
            if (is_alloc)
            begin
                res_id_reg     <= full ? '0 : hint_ext[ID_W-1:0];
                res_status_reg <= full ? STAT_FULL : STAT_OK;
            end
            else
            begin
                res_id_reg     <= id_reg;
                res_status_reg <= bad_id ? STAT_BAD_ID : STAT_OK;
            end
        end
        if (dcmd.acc && is_lookup)
        begin
            res_found_reg  <= bm_rdata_reg[id_bit];
            res_handle_reg <= bm_rdata_reg[id_bit] ? h_rdata_reg : '0;
        end
        if (dcmd.out_load)
        begin
            id_out_reg     <= res_id_reg;
            handle_out_reg <= res_handle_reg;
            found_reg      <= res_found_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign id_out     = id_out_reg;
    assign handle_out = handle_out_reg;
    assign found      = found_reg;
    assign status     = status_reg;

endmodule
`default_nettype wire

### test/lowest_free_slot_allocator_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_tb
// Self-checking bench for the slot allocator. A command queue feeds a clocked
// driver; each accepted transfer is run through a local pool model and the
// expected result is queued. A clocked monitor compares each result transfer
// field by field. Both sides idle at random, outside one long window without breaks.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_tb;

    import lfsa_pkg::*;

    localparam int SLOTS      = LFSA_SLOTS;
    localparam int RAND_ITEMS = 1400;
    localparam int FILL_START = 150;
    localparam int DRAIN_WAIT = 64;
    localparam int QUIET_LO   = 3000;
    localparam int QUIET_HI   = 7000;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ID_W-1:0]     slot_id;
        logic [HANDLE_W-1:0] handle;
    } slot_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic                found;
        logic [STATUS_W-1:0] status;
    } slot_result_t;

    typedef struct packed {
        logic [SLOTS-1:0]                used;
        logic [SLOTS-1:0][HANDLE_W-1:0] hnd;
        logic [31:0]                     hint;
    } pool_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd        = CMD_ALLOC;
    logic [ID_W-1:0]     slot_id    = '0;
    logic [HANDLE_W-1:0] handle     = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [ID_W-1:0]     id_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                found;
    logic [STATUS_W-1:0] status;

    slot_cmd_t    cmd_q[$];
    slot_result_t result_q[$];
    pool_t        tracked_pool;
    pool_t        plan_pool;
    slot_cmd_t    drv_item;
    slot_result_t want;
    int           err_count = 0;
    int           n_queued  = 0;
    int           cyc       = 0;
    logic         quiet;

    lowest_free_slot_allocator #(
        .SLOTS(SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .slot_id   (slot_id),
        .handle    (handle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .id_out    (id_out),
        .handle_out(handle_out),
        .found     (found),
        .status    (status)
    );

    // clock
    always #5 clk = ~clk;

    // cycle count for the quiet window
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    assign quiet = (cyc >= QUIET_LO) && (cyc < QUIET_HI);

    // one command applied to a pool, returns its result
    function automatic slot_result_t pool_step(inout pool_t p, input slot_cmd_t c);
        slot_result_t r;
        int unsigned  i;
        r        = '0;
        r.id     = c.slot_id;
        r.status = STAT_OK;
        if (c.cmd == CMD_ALLOC)
        begin
            if (p.hint >= SLOTS)
            begin
                p.hint   = SLOTS;
                r.id     = '0;
                r.status = STAT_FULL;
            end
            else
            begin
                r.id   = p.hint[ID_W-1:0];
                i      = p.hint + 1;
                p.hint = SLOTS;
                // lowest free slot above the one handed out
                while (i < SLOTS && p.hint == SLOTS)
                begin
                    if (!p.used[i])
                        p.hint = i;
                    i++;
                end
            end
        end
        else if (c.slot_id >= SLOTS)
        begin
            r.status = STAT_BAD_ID;
        end
        else
        begin
            case (c.cmd)
                CMD_REGISTER:
                begin
                    p.hnd[c.slot_id]  = c.handle;
                    p.used[c.slot_id] = 1'b1;
                    if (c.slot_id == p.hint)
                        p.hint = c.slot_id + 1;
                end
                CMD_FREE:
                begin
                    if (c.slot_id < p.hint)
                        p.hint = c.slot_id;
                    p.used[c.slot_id] = 1'b0;
                end
                CMD_LOOKUP:
                begin
                    if (p.used[c.slot_id])
                    begin
                        r.handle = p.hnd[c.slot_id];
                        r.found  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return r;
    endfunction

    // random used slot, or a random slot when none is used
    function automatic logic [ID_W-1:0] pick_used(input pool_t p);
        int unsigned start;
        int unsigned idx;
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++)
        begin
            idx = (start + k) % SLOTS;
            if (p.used[idx])
                return idx[ID_W-1:0];
        end
        return start[ID_W-1:0];
    endfunction

    // random idle decision, off during the quiet window
    function automatic logic take_break();
        return !quiet && ($urandom_range(0, 99) < 21);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    // queue one command and track its effect on the planning pool
    task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                             input logic [HANDLE_W-1:0] h, output slot_result_t r);
        slot_cmd_t item;
        item.cmd     = c;
        item.slot_id = id;
        item.handle  = h;
        cmd_q.push_back(item);
        r = pool_step(plan_pool, item);
        n_queued++;
    endtask

    // well-formed pair: allocate, then register the slot handed out
    task automatic alloc_and_register();
        slot_result_t r;
        queue_cmd(CMD_ALLOC, ID_W'($urandom), $urandom, r);
        if (r.status == STAT_OK)
            queue_cmd(CMD_REGISTER, r.id, $urandom, r);
    endtask

    // driver: present queued commands, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= CMD_ALLOC;
            slot_id  <= '0;
            handle   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                result_q.push_back(pool_step(tracked_pool,
                                             slot_cmd_t'({cmd, slot_id, handle})));
            if (!in_valid || !in_stall)
            begin
                if (cmd_q.size() != 0 && !take_break())
                begin
                    drv_item = cmd_q.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= drv_item.cmd;
                    slot_id  <= drv_item.slot_id;
                    handle   <= drv_item.handle;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = result_q.pop_front();
                    if (id_out !== want.id)
                        report_mismatch($sformatf("id_out got %0d want %0d",
                                                  id_out, want.id));
                    if (handle_out !== want.handle)
                        report_mismatch($sformatf("handle_out got %h want %h",
                                                  handle_out, want.handle));
                    if (found !== want.found)
                        report_mismatch($sformatf("found got %b want %b",
                                                  found, want.found));
                    if (status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, want.status));
                end
            end
            out_stall <= take_break();
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        slot_result_t r;
        int           pick;
        int           filled_at;
        logic         filled;

        tracked_pool = '0;
        plan_pool    = '0;

        // directed: empty pool, hint on a used slot, overwrite, extremes
        queue_cmd(CMD_LOOKUP,   10'd0,    32'h0000_0000, r);
        queue_cmd(CMD_ALLOC,    10'd0,    32'h0000_0000, r);
        queue_cmd(CMD_ALLOC,    10'd1023, 32'hFFFF_FFFF, r);
        queue_cmd(CMD_REGISTER, 10'd3,    32'hFFFF_FFFF, r);
        queue_cmd(CMD_REGISTER, 10'd2,    32'h0000_0000, r);
        queue_cmd(CMD_ALLOC,    10'd0,    32'h0000_0000, r);
        queue_cmd(CMD_LOOKUP,   10'd3,    32'h0000_0000, r);
        queue_cmd(CMD_LOOKUP,   10'd2,    32'hFFFF_FFFF, r);
        queue_cmd(CMD_REGISTER, 10'd1023, 32'hA5A5_A5A5, r);
        queue_cmd(CMD_REGISTER, 10'd1023, 32'h5A5A_5A5A, r);
        queue_cmd(CMD_LOOKUP,   10'd1023, 32'h0000_0000, r);
        queue_cmd(CMD_FREE,     10'd2,    32'h0000_0000, r);
        queue_cmd(CMD_FREE,     10'd500,  32'h0000_0000, r);
        queue_cmd(CMD_ALLOC,    10'd0,    32'h0000_0000, r);
        queue_cmd(CMD_REGISTER, plan_pool.hint[ID_W-1:0], $urandom, r);
        queue_cmd(CMD_FREE,     10'd1023, 32'h0000_0000, r);
        queue_cmd(CMD_LOOKUP,   10'd1023, 32'h0000_0000, r);
        queue_cmd(CMD_REGISTER, 10'd0,    $urandom, r);
        queue_cmd(CMD_LOOKUP,   10'd0,    32'h0000_0000, r);
        queue_cmd(CMD_FREE,     10'd0,    32'h0000_0000, r);
        queue_cmd(CMD_LOOKUP,   10'd1,    32'h0000_0000, r);

        // random: mixed traffic, then a fill run to a full pool, then mixed again
        filled    = 1'b0;
        filled_at = 0;
        n_queued  = 0;
        while (!filled || n_queued < RAND_ITEMS || n_queued < filled_at + 100)
        begin
            pick = $urandom_range(0, 99);
            if (n_queued >= FILL_START && !filled)
            begin
                if (pick < 85)
                    queue_cmd(CMD_REGISTER, plan_pool.hint[ID_W-1:0], $urandom, r);
                else
                    alloc_and_register();
            end
            else if (pick < 35)
                alloc_and_register();
            else if (pick < 45)
                queue_cmd(CMD_ALLOC, ID_W'($urandom), $urandom, r);
            else if (pick < 55)
                queue_cmd(CMD_REGISTER, (plan_pool.hint < SLOTS) ?
                          plan_pool.hint[ID_W-1:0] : ID_W'($urandom), $urandom, r);
            else if (pick < 70)
                queue_cmd(CMD_LOOKUP, pick_used(plan_pool), $urandom, r);
            else if (pick < 80)
                queue_cmd(CMD_FREE, pick_used(plan_pool), $urandom, r);
            else if (pick < 85)
                queue_cmd(CMD_FREE, ID_W'($urandom), $urandom, r);
            else if (pick < 92)
                queue_cmd(CMD_LOOKUP, ID_W'($urandom), $urandom, r);
            else if (pick < 97)
                queue_cmd(CMD_REGISTER, ID_W'($urandom), $urandom, r);
            else
                queue_cmd(CMD_W'($urandom), ID_W'($urandom), $urandom, r);
            if (!filled && plan_pool.hint >= SLOTS)
            begin
                filled    = 1'b1;
                filled_at = n_queued;
            end
        end

        // reset
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // drain: sample away from the active edge so queue and valid agree
        while (cmd_q.size() != 0 || in_valid || result_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (result_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      result_q.size()));
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
